### sv/cgp_pkg.sv
// shared types and constants of the cgp netlist evaluator
// request and result structs, function codes, register indexes
package cgp_pkg;

    localparam int GATE_INPUTS     = 2;
    localparam int DEF_MAX_GATES   = 64;
    localparam int DEF_MAX_INPUTS  = 64;
    localparam int DEF_MAX_OUTPUTS = 64;
    localparam int DEF_GATE_OUTPUTS = 2;
    localparam int GENE_BITS       = 10;
    localparam int WRAP_SPAN       = 256;
    localparam int FOLD_SHIFT      = 7;

    typedef enum logic [1:0] {
        K_GENE = 2'd0,
        K_PIN  = 2'd1,
        K_EVAL = 2'd2,
        K_NONE = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        R_INPUT_COUNT  = 3'd0,
        R_OUTPUT_COUNT = 3'd1,
        R_GATE_COUNT   = 3'd2,
        R_VALUE_MIN    = 3'd3,
        R_VALUE_MAX    = 3'd4,
        R_SHIFT_MASK   = 3'd5
    } t_reg_idx;

    localparam logic [9:0] F_PASS = 10'd0;
    localparam logic [9:0] F_RSUB = 10'd1;
    localparam logic [9:0] F_ADD  = 10'd2;
    localparam logic [9:0] F_SUB  = 10'd3;
    localparam logic [9:0] F_MUL  = 10'd4;
    localparam logic [9:0] F_NEG  = 10'd5;
    localparam logic [9:0] F_MADD = 10'd6;
    localparam logic [9:0] F_ASR2 = 10'd7;
    localparam logic [9:0] F_ASR1 = 10'd8;
    localparam logic [9:0] F_AND  = 10'd9;
    localparam logic [9:0] F_OR   = 10'd10;
    localparam logic [9:0] F_XOR  = 10'd11;
    localparam logic [9:0] F_NOT  = 10'd12;
    localparam logic [9:0] F_LSL1 = 10'd13;
    localparam logic [9:0] F_INC  = 10'd14;
    localparam logic [9:0] F_DEC  = 10'd15;
    localparam logic [9:0] F_ASR3 = 10'd16;
    localparam logic [9:0] F_ASR4 = 10'd17;
    localparam logic [9:0] F_ASR5 = 10'd18;
    localparam logic [9:0] F_LSL2 = 10'd19;
    localparam logic [9:0] F_LSL3 = 10'd20;
    localparam logic [9:0] F_LSL4 = 10'd21;
    localparam logic [9:0] F_LSL5 = 10'd22;
    localparam logic [9:0] F_ONE  = 10'd23;
    localparam logic [9:0] F_MONE = 10'd24;
    localparam logic [9:0] F_ZERO = 10'd25;
    localparam logic [9:0] F_VMIN = 10'd26;
    localparam logic [9:0] F_VMAX = 10'd27;
    localparam logic [9:0] F_MUX  = 10'd28;
    localparam logic [9:0] F_DEMUX = 10'd29;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         address;
        logic signed [31:0] value;
        logic               selector;
    } t_req;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [5:0]         output_index;
        logic               last;
    } t_rsp;

endpackage

### sv/cgp_netlist_evaluator_top.sv
// cgp netlist evaluator: gene and pin memories with a sequential gate walker
// depends on cgp_pkg
// load requests complete when accepted; an evaluation steps each gate through S_G0 to S_G3
// and one S_GW pin write per gate output, then steps each output through S_O0 to S_O2
// throughput: one evaluation at a time, as start is not accepted while busy; single pin memory write port
// reset: synchronous, resets the state and config registers and clears all pin valid bits (pins read zero)
// results leave as one-cycle strobes; the receiver cannot stall
module cgp_netlist_evaluator_top
    import cgp_pkg::*;
#(
    parameter int MAX_GATES    = DEF_MAX_GATES,
    parameter int MAX_INPUTS   = DEF_MAX_INPUTS,
    parameter int MAX_OUTPUTS  = DEF_MAX_OUTPUTS,
    parameter int GATE_OUTPUTS = DEF_GATE_OUTPUTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_req        i_req,
    output logic        o_valid,
    output t_rsp        o_rsp,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int GENE_DEPTH = MAX_GATES * (GATE_INPUTS + 1) + MAX_OUTPUTS;
    localparam int PIN_DEPTH  = MAX_INPUTS + MAX_GATES * GATE_OUTPUTS;
    localparam int GW = $clog2(GENE_DEPTH);
    localparam int PW = $clog2(PIN_DEPTH);
    localparam int CW = $clog2(MAX_GATES + 1);
    localparam int KW = $clog2(MAX_OUTPUTS + 1);
    localparam int JW = $clog2(GATE_OUTPUTS);

    typedef enum logic [3:0] {
        S_IDLE, S_G0, S_G1, S_G2, S_G3, S_GW, S_O0, S_O1, S_O2
    } t_state;

    logic [GENE_BITS-1:0] gene_mem [GENE_DEPTH];
    logic [31:0]          pin_mem  [PIN_DEPTH];
    logic [PIN_DEPTH-1:0] r_pin_vld;

    t_state r_state;
    logic [6:0]  r_input_count, r_output_count, r_gate_count;
    logic [31:0] r_vmin, r_shift_mask;
    logic [30:0] r_vmax;

    logic [GENE_BITS-1:0] r_qa, r_qb;
    logic [31:0] r_pa, r_pb_d;
    logic        r_pa_ok, r_pb_ok;
    logic [31:0] r_a, r_b, r_v;
    logic [9:0]  r_fn;
    logic signed [63:0] r_prod;
    logic        r_sel;
    logic [CW-1:0] r_g;
    logic [GW-1:0] r_gb;
    logic [PW-1:0] r_pbase;
    logic [JW:0]   r_j;
    logic [KW-1:0] r_k;
    logic        r_valid;
    t_rsp        r_rsp;

    logic [PW-1:0] ic;
    logic [CW-1:0] gc;
    logic [KW-1:0] oc;
    logic [GW-1:0] gene_ra, gene_rb;
    logic          pin_we;
    logic [PW-1:0] pin_wa;
    logic [31:0]   pin_wd, pin_w, pa, pb, gate_v;
    logic          accept;

    assign ic = (32'(r_input_count) > MAX_INPUTS) ? PW'(MAX_INPUTS) : PW'(r_input_count);
    assign gc = (32'(r_gate_count) > MAX_GATES) ? CW'(MAX_GATES) : CW'(r_gate_count);
    assign oc = (32'(r_output_count) > MAX_OUTPUTS) ? KW'(MAX_OUTPUTS)
                                                     : KW'(r_output_count);

    assign busy        = (r_state != S_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = !busy;
    assign o_valid     = r_valid;
    assign o_rsp       = r_rsp;

    assign pa = r_pa_ok ? r_pa : 32'd0;
    assign pb = r_pb_ok ? r_pb_d : 32'd0;

    always_comb begin
        case (r_state)
            S_G1:    gene_ra = r_gb + GW'(GATE_INPUTS);
            S_O0:    gene_ra = r_gb + GW'(r_k);
            default: gene_ra = r_gb;
        endcase
        gene_rb = r_gb + GW'(1);
    end

    function automatic logic [31:0] wrap_add(input logic signed [33:0] x,
                                             input logic signed [33:0] y,
                                             input logic [31:0] vmin,
                                             input logic [30:0] vmax);
        logic signed [33:0] s;
        s = x + y;
        if (s > $signed({3'b000, vmax})) begin
            s = s - 34'sd256;
        end else if (s < $signed({{2{vmin[31]}}, vmin})) begin
            s = s + 34'sd256;
        end
        return s[31:0];
    endfunction

    function automatic logic [31:0] fold_mul(input logic signed [63:0] c,
                                             input logic [31:0] vmin,
                                             input logic [30:0] vmax);
        logic [63:0] m;
        logic [31:0] r;
        logic [31:0] res;
        m = c[63] ? 64'(-c) : 64'(c);
        r = {25'd0, m[FOLD_SHIFT-1:0]};
        if (c > $signed({33'd0, vmax})) begin
            res = m[FOLD_SHIFT] ? (vmin + r) : r;
        end else if (c < $signed({{32{vmin[31]}}, vmin})) begin
            res = m[FOLD_SHIFT] ? ({1'b0, vmax} + 32'd1 - r) : (32'd0 - r);
        end else begin
            res = c[31:0];
        end
        return res;
    endfunction

    always_comb begin
        logic signed [33:0] sa, sb, svmax, svmin;
        sa    = {{2{r_a[31]}}, r_a};
        sb    = {{2{r_b[31]}}, r_b};
        svmax = {3'b000, r_vmax};
        svmin = {{2{r_vmin[31]}}, r_vmin};
        case (r_fn)
            F_PASS:  gate_v = r_a;
            F_RSUB:  gate_v = wrap_add(svmax, -sa, r_vmin, r_vmax);
            F_ADD:   gate_v = wrap_add(sa, sb, r_vmin, r_vmax);
            F_SUB:   gate_v = wrap_add(sa, -sb, r_vmin, r_vmax);
            F_MUL:   gate_v = fold_mul(r_prod, r_vmin, r_vmax);
            F_NEG:   gate_v = 32'd0 - r_a;
            F_MADD:  gate_v = wrap_add(svmin, sa, r_vmin, r_vmax);
            F_ASR2:  gate_v = 32'($signed(r_a) >>> 2) & r_shift_mask;
            F_ASR1:  gate_v = 32'($signed(r_a) >>> 1) & r_shift_mask;
            F_AND:   gate_v = r_a & r_b;
            F_OR:    gate_v = r_a | r_b;
            F_XOR:   gate_v = r_a ^ r_b;
            F_NOT:   gate_v = ~r_a;
            F_LSL1:  gate_v = (r_a << 1) & r_shift_mask;
            F_INC:   gate_v = wrap_add(sa, 34'sd1, r_vmin, r_vmax);
            F_DEC:   gate_v = wrap_add(sa, -34'sd1, r_vmin, r_vmax);
            F_ASR3:  gate_v = 32'($signed(r_a) >>> 3) & r_shift_mask;
            F_ASR4:  gate_v = 32'($signed(r_a) >>> 4) & r_shift_mask;
            F_ASR5:  gate_v = 32'($signed(r_a) >>> 5) & r_shift_mask;
            F_LSL2:  gate_v = (r_a << 2) & r_shift_mask;
            F_LSL3:  gate_v = (r_a << 3) & r_shift_mask;
            F_LSL4:  gate_v = (r_a << 4) & r_shift_mask;
            F_LSL5:  gate_v = (r_a << 5) & r_shift_mask;
            F_ONE:   gate_v = 32'd1;
            F_MONE:  gate_v = 32'hffff_ffff;
            F_ZERO:  gate_v = 32'd0;
            F_VMIN:  gate_v = r_vmin;
            F_VMAX:  gate_v = {1'b0, r_vmax};
            F_MUX:   gate_v = r_sel ? r_b : r_a;
            F_DEMUX: gate_v = r_a;
            default: gate_v = 32'hffff_ffff;
        endcase
    end

    assign pin_w = (r_fn == F_DEMUX && r_j != (JW+1)'(r_sel)) ? 32'd0 : r_v;

    always_comb begin
        pin_we = 1'b0;
        pin_wa = r_pbase + PW'(r_j);
        pin_wd = pin_w;
        if (r_state == S_GW) begin
            pin_we = 1'b1;
        end else if (accept && i_req.kind == K_PIN
                     && {1'b0, i_req.address} < 9'(ic)) begin
            pin_we = 1'b1;
            pin_wa = PW'(i_req.address);
            pin_wd = i_req.value;
        end
    end

    // gene memory
    always_ff @(posedge i_clk) begin
        if (accept && i_req.kind == K_GENE && 32'(i_req.address) < GENE_DEPTH) begin
            gene_mem[GW'(i_req.address)] <= i_req.value[GENE_BITS-1:0];
        end
        r_qa <= gene_mem[gene_ra];
        r_qb <= gene_mem[gene_rb];
    end

    // pin memory
    always_ff @(posedge i_clk) begin
        if (pin_we) begin
            pin_mem[pin_wa] <= pin_wd;
        end
        r_pa   <= pin_mem[r_qa[PW-1:0]];
        r_pb_d <= pin_mem[r_qb[PW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pin_vld <= '0;
            r_pa_ok   <= 1'b0;
            r_pb_ok   <= 1'b0;
        end else begin
            if (pin_we) begin
                r_pin_vld[pin_wa] <= 1'b1;
            end
            r_pa_ok <= (32'(r_qa) < PIN_DEPTH) && r_pin_vld[r_qa[PW-1:0]];
            r_pb_ok <= (32'(r_qb) < PIN_DEPTH) && r_pin_vld[r_qb[PW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_count  <= 7'd1;
            r_output_count <= 7'd1;
            r_gate_count   <= 7'd1;
            r_vmin         <= 32'hffff_ff80;
            r_vmax         <= 31'd127;
            r_shift_mask   <= 32'd255;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                R_INPUT_COUNT:  r_input_count  <= i_cfg_data[6:0];
                R_OUTPUT_COUNT: r_output_count <= i_cfg_data[6:0];
                R_GATE_COUNT:   r_gate_count   <= i_cfg_data[6:0];
                R_VALUE_MIN:    r_vmin         <= i_cfg_data;
                R_VALUE_MAX:    r_vmax         <= i_cfg_data[30:0];
                R_SHIFT_MASK:   r_shift_mask   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_g     <= '0;
            r_gb    <= '0;
            r_pbase <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_sel   <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept && i_req.kind == K_EVAL) begin
                        r_g     <= '0;
                        r_gb    <= '0;
                        r_k     <= '0;
                        r_pbase <= ic;
                        r_sel   <= i_req.selector;
                        if (gc != '0) begin
                            r_state <= S_G0;
                        end else if (oc != '0) begin
                            r_state <= S_O0;
                        end
                    end
                end
                S_G0: r_state <= S_G1;
                S_G1: r_state <= S_G2;
                S_G2: begin
                    r_a     <= pa;
                    r_b     <= pb;
                    r_fn    <= r_qa;
                    r_prod  <= $signed(pa) * $signed(pb);
                    r_state <= S_G3;
                end
                S_G3: begin
                    r_v     <= gate_v;
                    r_j     <= '0;
                    r_state <= S_GW;
                end
                S_GW: begin
                    if (r_j == (JW+1)'(GATE_OUTPUTS - 1)) begin
                        r_pbase <= r_pbase + PW'(GATE_OUTPUTS);
                        r_gb    <= r_gb + GW'(GATE_INPUTS + 1);
                        r_g     <= r_g + CW'(1);
                        if (r_g + CW'(1) == gc) begin
                            r_state <= (oc != '0) ? S_O0 : S_IDLE;
                        end else begin
                            r_state <= S_G0;
                        end
                    end else begin
                        r_j <= r_j + (JW+1)'(1);
                    end
                end
                S_O0: r_state <= S_O1;
                S_O1: r_state <= S_O2;
                S_O2: begin
                    r_valid            <= 1'b1;
                    r_rsp.result_value <= pa;
                    r_rsp.output_index <= 6'(r_k);
                    r_rsp.last         <= (r_k + KW'(1) == oc);
                    if (r_k + KW'(1) == oc) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_k     <= r_k + KW'(1);
                        r_state <= S_O0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### verif/tb_cgp_netlist_evaluator_top.sv
// self-checking testbench for cgp_netlist_evaluator_top: directed table, then random phases
// compares every result strobe against a netlist predictor; depends on cgp_pkg
module tb_cgp_netlist_evaluator_top;
    import cgp_pkg::*;

    typedef struct {
        t_req        req;
        bit          typed;
        logic [31:0] typed_value;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_req        i_req = '0;
    logic        o_valid;
    t_rsp        o_rsp;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    // netlist state as the block should hold it
    logic [9:0]         gene_mem [256];
    logic [31:0]        pin_mem [192];
    logic [6:0]         n_inputs = 7'd1, n_outputs = 7'd1, n_gates = 7'd1;
    logic signed [31:0] wrap_lo = -32'sd128;
    logic [30:0]        wrap_hi = 31'd127;
    logic [31:0]        shift_and = 32'd255;

    t_rsp  pending_rsp [$];
    t_row  directed_rows [$];
    int    errors = 0;
    int    cycles = 0;
    int    load_count = 0;
    bit    quiet = 1'b0;

    cgp_netlist_evaluator_top DUT (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 1000000) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_rsp.size() == 0) begin
                report("result with nothing pending", o_rsp.result_value, 0);
            end else begin
                t_rsp want;
                want = pending_rsp.pop_front();
                if (o_rsp.result_value !== want.result_value)
                    report("result_value", o_rsp.result_value, want.result_value);
                if (o_rsp.output_index !== want.output_index)
                    report("output_index", o_rsp.output_index, want.output_index);
                if (o_rsp.last !== want.last)
                    report("last", o_rsp.last, want.last);
            end
        end
    end

    function automatic logic [31:0] wrap_add(longint a, longint b);
        longint s;
        s = a + b;
        if (s > longint'(wrap_hi)) s -= 256;
        else if (s < longint'(wrap_lo)) s += 256;
        return s[31:0];
    endfunction

    function automatic logic [31:0] fold_mul(longint a, longint b);
        longint c, m, p, r, v;
        c = a * b;
        m = c < 0 ? -c : c;
        p = m / 128;
        r = m % 128;
        if (c > longint'(wrap_hi))
            v = p[0] ? longint'(wrap_lo) + r : r;
        else if (c < longint'(wrap_lo))
            v = p[0] ? longint'(wrap_hi) + 1 - r : -r;
        else
            v = c;
        return v[31:0];
    endfunction

    function automatic logic [31:0] shr(logic [31:0] a, int n);
        logic [31:0] t;
        t = $signed(a) >>> n;
        return t & shift_and;
    endfunction

    function automatic logic [31:0] shl(logic [31:0] a, int n);
        return (a << n) & shift_and;
    endfunction

    function automatic logic [31:0] read_pin(int idx);
        return idx < 192 ? pin_mem[idx] : 32'd0;
    endfunction

    function automatic logic [31:0] gate_value(logic [9:0] fn, logic [31:0] a,
                                               logic [31:0] b, logic sel);
        longint sa, sb;
        sa = longint'($signed(a));
        sb = longint'($signed(b));
        case (fn)
            F_PASS:  return a;
            F_RSUB:  return wrap_add(longint'(wrap_hi), -sa);
            F_ADD:   return wrap_add(sa, sb);
            F_SUB:   return wrap_add(sa, -sb);
            F_MUL:   return fold_mul(sa, sb);
            F_NEG:   return -a;
            F_MADD:  return wrap_add(longint'(wrap_lo), sa);
            F_ASR2:  return shr(a, 2);
            F_ASR1:  return shr(a, 1);
            F_AND:   return a & b;
            F_OR:    return a | b;
            F_XOR:   return a ^ b;
            F_NOT:   return ~a;
            F_LSL1:  return shl(a, 1);
            F_INC:   return wrap_add(sa, 1);
            F_DEC:   return wrap_add(sa, -1);
            F_ASR3:  return shr(a, 3);
            F_ASR4:  return shr(a, 4);
            F_ASR5:  return shr(a, 5);
            F_LSL2:  return shl(a, 2);
            F_LSL3:  return shl(a, 3);
            F_LSL4:  return shl(a, 4);
            F_LSL5:  return shl(a, 5);
            F_ONE:   return 32'd1;
            F_MONE:  return 32'hffffffff;
            F_ZERO:  return 32'd0;
            F_VMIN:  return wrap_lo;
            F_VMAX:  return {1'b0, wrap_hi};
            F_MUX:   return sel ? b : a;
            F_DEMUX: return a;
            default: return 32'hffffffff;
        endcase
    endfunction

    // applies one request to the netlist state and queues the outputs it yields
    task automatic run_netlist(t_req r, bit typed, logic [31:0] typed_value);
        int ic, oc, gc, gb, pb;
        logic [31:0] a, b, v, w;
        logic [9:0] fn;
        t_rsp rsp;
        ic = n_inputs > 64 ? 64 : n_inputs;
        oc = n_outputs > 64 ? 64 : n_outputs;
        gc = n_gates > 64 ? 64 : n_gates;
        case (t_kind'(r.kind))
            K_GENE: gene_mem[r.address] = r.value[9:0];
            K_PIN: begin
                if (r.address < ic) pin_mem[r.address] = r.value;
            end
            K_EVAL: begin
                for (int g = 0; g < gc; g++) begin
                    gb = g * 3;
                    a = read_pin(gene_mem[gb]);
                    b = read_pin(gene_mem[gb + 1]);
                    fn = gene_mem[gb + 2];
                    v = gate_value(fn, a, b, r.selector);
                    pb = ic + g * 2;
                    for (int j = 0; j < 2; j++) begin
                        w = (fn == F_DEMUX && j != r.selector) ? 32'd0 : v;
                        if (pb + j < 192) pin_mem[pb + j] = w;
                    end
                end
                for (int k = 0; k < oc; k++) begin
                    rsp.result_value = read_pin(gene_mem[gc * 3 + k]);
                    rsp.output_index = k[5:0];
                    rsp.last = (k + 1 == oc);
                    if (k == 0 && typed) rsp.result_value = typed_value;
                    pending_rsp = {pending_rsp, rsp};
                end
            end
            default: ;
        endcase
    endtask

    task automatic send(t_req r, bit typed = 1'b0, logic [31:0] typed_value = '0);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        run_netlist(r, typed, typed_value);
        if (t_kind'(r.kind) != K_NONE) load_count++;
    endtask

    task automatic drain;
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_rsp.size() != 0 || busy) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [31:0] data);
        if (!quiet && $urandom_range(0, 2) == 0) begin
            i_cfg_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            R_INPUT_COUNT:  n_inputs = data[6:0];
            R_OUTPUT_COUNT: n_outputs = data[6:0];
            R_GATE_COUNT:   n_gates = data[6:0];
            R_VALUE_MIN:    wrap_lo = data;
            R_VALUE_MAX:    wrap_hi = data[30:0];
            R_SHIFT_MASK:   shift_and = data;
            default: ;
        endcase
    endtask

    function automatic t_req make_req(t_kind k, int addr, logic [31:0] v, logic sel);
        t_req r;
        r.kind = k;
        r.address = addr[7:0];
        r.value = v;
        r.selector = sel;
        return r;
    endfunction

    task automatic add_row(t_kind k, int addr, logic [31:0] v, logic sel,
                           bit typed = 1'b0, logic [31:0] typed_value = '0);
        t_row row;
        row.req = make_req(k, addr, v, sel);
        row.typed = typed;
        row.typed_value = typed_value;
        directed_rows = {directed_rows, row};
    endtask

    function automatic logic [31:0] gene_word(logic [9:0] g);
        return {22'($urandom() >> 10), g};
    endfunction

    function automatic logic [31:0] sample_word();
        case ($urandom_range(0, 4))
            0:       return 32'h80000000;
            1:       return 32'h7fffffff;
            2:       return $urandom();
            default: return $urandom_range(0, 600) - 300;
        endcase
    endfunction

    initial begin
        int ic, oc, gc, phase, span;
        logic [31:0] data;
        t_row row;

        for (int i = 0; i < 192; i++) pin_mem[i] = '0;
        for (int i = 0; i < 256; i++) gene_mem[i] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // one gate reading pin 0 twice, output read from pin 1 and later from pin 2
        add_row(K_GENE, 0, 32'd0, 1'b0);
        add_row(K_GENE, 1, 32'd0, 1'b0);
        add_row(K_GENE, 3, 32'd1, 1'b0);
        add_row(K_GENE, 2, F_VMAX, 1'b0);
        add_row(K_EVAL, 0, 32'd0, 1'b0, 1'b1, 32'd127);
        add_row(K_GENE, 2, F_VMIN, 1'b0);
        add_row(K_EVAL, 0, 32'd0, 1'b1, 1'b1, 32'hffffff80);
        add_row(K_PIN, 0, 32'h7fffffff, 1'b0);
        add_row(K_GENE, 2, F_PASS, 1'b0);
        add_row(K_EVAL, 0, 32'd0, 1'b0, 1'b1, 32'h7fffffff);
        add_row(K_PIN, 0, 32'h80000000, 1'b1);
        add_row(K_GENE, 2, F_NOT, 1'b0);
        add_row(K_EVAL, 0, 32'd0, 1'b0, 1'b1, 32'h7fffffff);
        add_row(K_GENE, 2, 32'hffffffff, 1'b0);
        add_row(K_EVAL, 0, 32'd0, 1'b0, 1'b1, 32'hffffffff);
        add_row(K_GENE, 2, F_DEMUX, 1'b0);
        add_row(K_GENE, 3, 32'd2, 1'b0);
        add_row(K_EVAL, 0, 32'd0, 1'b0, 1'b1, 32'd0);
        add_row(K_EVAL, 0, 32'd0, 1'b1, 1'b1, 32'h80000000);
        add_row(K_PIN, 255, 32'h1234, 1'b0);
        add_row(K_GENE, 255, 32'h3ff, 1'b0);
        add_row(K_NONE, 0, 32'hffffffff, 1'b1);
        add_row(K_GENE, 2, F_MUX, 1'b0);
        add_row(K_EVAL, 255, 32'hffffffff, 1'b1);
        add_row(K_GENE, 2, F_MUL, 1'b0);
        add_row(K_EVAL, 0, 32'd0, 1'b0);
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send(row.req, row.typed, row.typed_value);
        end

        phase = 0;
        while (load_count < 470) begin
            phase++;
            drain();
            quiet = load_count > 400 || phase % 3 == 0;
            case (phase)
                1: begin ic = 64;  gc = 4;   oc = 4;  end
                2: begin ic = 3;   gc = 8;   oc = 1;  end
                3: begin ic = 1;   gc = 1;   oc = 64; end
                4: begin ic = 127; gc = 100; oc = 2;  end
                5: begin ic = 2;   gc = 3;   oc = 0;  end
                default: begin
                    ic = $urandom_range(1, 12);
                    gc = $urandom_range(1, 8);
                    oc = $urandom_range(1, 6);
                end
            endcase
            write_reg(R_INPUT_COUNT, {25'($urandom() >> 7), ic[6:0]});
            write_reg(R_OUTPUT_COUNT, {25'($urandom() >> 7), oc[6:0]});
            write_reg(R_GATE_COUNT, {25'($urandom() >> 7), gc[6:0]});
            case (phase)
                1: data = 32'h80000000;
                2: data = 32'd0;
                default: data = $urandom_range(0, 1) ? -$urandom_range(0, 300)
                                                     : $urandom() | 32'h80000000;
            endcase
            write_reg(R_VALUE_MIN, data);
            case (phase)
                1: data = 32'h7fffffff;
                2: data = 32'h80000000;
                default: data = {$urandom_range(0, 1) == 1,
                                 $urandom_range(0, 1) ? 31'($urandom_range(0, 300)) : 31'($urandom())};
            endcase
            write_reg(R_VALUE_MAX, data);
            case (phase)
                1: data = 32'hffffffff;
                2: data = 32'd0;
                default: data = $urandom_range(0, 1) ? 32'd255 : $urandom();
            endcase
            write_reg(R_SHIFT_MASK, data);
            if (phase % 4 == 0) write_reg(t_reg_idx'(3'd6 + phase % 8 / 4), $urandom());
            i_cfg_valid <= 1'b0;

            ic = ic > 64 ? 64 : ic;
            gc = gc > 64 ? 64 : gc;
            span = ic + 2 * gc + 1;
            for (int g = 0; g < gc; g++) begin
                for (int j = 0; j < 2; j++)
                    send(make_req(K_GENE, g * 3 + j, gene_word($urandom_range(0, 7) == 0 ?
                         10'($urandom_range(0, 1023)) : 10'($urandom_range(0, span))), 1'b0));
                send(make_req(K_GENE, g * 3 + 2, gene_word($urandom_range(0, 7) == 0 ?
                     10'($urandom_range(0, 1023)) : 10'($urandom_range(0, 31))), 1'b0));
            end
            for (int k = 0; k < oc; k++)
                send(make_req(K_GENE, gc * 3 + k,
                     gene_word(10'($urandom_range(0, span + 2))), 1'b0));
            for (int i = 0; i < (ic > 8 ? 8 : ic); i++)
                send(make_req(K_PIN, $urandom_range(0, ic - 1), sample_word(),
                              1'($urandom())));

            repeat (15) begin
                case ($urandom_range(0, 9))
                    0, 1: send(make_req(K_PIN, $urandom_range(0, 1) ? $urandom_range(0, ic) :
                               $urandom_range(0, 255), sample_word(), 1'($urandom())));
                    2: send(make_req(K_GENE, $urandom_range(0, 255), $urandom(),
                                     1'($urandom())));
                    3: send(make_req(K_NONE, $urandom_range(0, 255), $urandom(),
                                     1'($urandom())));
                    default: send(make_req(K_EVAL, $urandom_range(0, 255), $urandom(),
                                           1'($urandom())));
                endcase
            end
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (pending_rsp.size() != 0 || busy) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0 && pending_rsp.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
